FILE: rtl/core/dmt_pkg.sv
// shared types, constants and the period table of the divider and modulo timer
package dmt_pkg;

    localparam logic [8:0]  DIV_PERIOD    = 9'd256;
    localparam logic [8:0]  DIV_PRE_RESET = 9'd52;
    localparam logic [10:0] CNT_PRE_RESET = 11'd1024;
    localparam logic [2:0]  RELOAD_STAGE  = 3'd5;
    localparam logic [7:0]  COUNT_MAX     = 8'hFF;

    // configuration register indexes
    localparam logic [1:0] CFG_RELOAD_VALUE = 2'd0;
    localparam logic [1:0] CFG_TIMER_ENABLE = 2'd1;
    localparam logic [1:0] CFG_CLOCK_SELECT = 2'd2;

    // clock select codes
    localparam logic [1:0] SEL_1024 = 2'd0;
    localparam logic [1:0] SEL_16   = 2'd1;
    localparam logic [1:0] SEL_64   = 2'd2;
    localparam logic [1:0] SEL_256  = 2'd3;

    typedef struct packed {
        logic [8:0]  div_pre;
        logic [7:0]  div_cnt;
        logic [10:0] cnt_pre;
        logic [10:0] active_period;
        logic [7:0]  mod_cnt;
        logic [2:0]  ovf_stage;
    } timer_state_t;

    typedef struct packed {
        logic [7:0] reload_value;
        logic       timer_enable;
        logic [1:0] clock_select;
    } timer_cfg_t;

    function automatic logic [10:0] period_of(input logic [1:0] sel);
        logic [10:0] p;
        begin
            case (sel)
                SEL_1024: p = 11'd1024;
                SEL_16:   p = 11'd16;
                SEL_64:   p = 11'd64;
                SEL_256:  p = 11'd256;
                default:  p = 11'd1024;
            endcase
            return p;
        end
    endfunction

endpackage

FILE: rtl/core/divider_and_modulo_timer.sv
// top level of the divider and modulo timer: input stage, timer state and result stage
//
//  channel   direction  handshake                     payload
//  tick      in         tick_valid / tick_ready       tick
//  result    out        result_valid / result_ready   divider_value, counter_value,
//                                                     timer_interrupt
//  config    in         cfg_wr_en                     cfg_index, cfg_data
//
// one beat per clock sustained while the result is not stalled; an accepted tick beat passes
// the input register, then the state update that loads the result register
// reset puts the prescalers at 52 and 1024 and clears counters and the reload stage
// a stalled result holds the result register; the input stage keeps one beat
// and stops taking beats only while both stages are full
module divider_and_modulo_timer
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       tick_valid,
    output logic       tick_ready,
    input  logic       tick,
    output logic       result_valid,
    input  logic       result_ready,
    output logic [7:0] divider_value,
    output logic [7:0] counter_value,
    output logic       timer_interrupt,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    dmt_pkg::timer_cfg_t   cfg_reg;
    dmt_pkg::timer_state_t state_reg;
    dmt_pkg::timer_state_t state_next;
    logic                  irq_next;
    logic                  in_valid_reg;
    logic                  in_tick_reg;
    logic                  out_valid_reg;
    logic [7:0]            div_out_reg;
    logic [7:0]            cnt_out_reg;
    logic                  irq_out_reg;
    logic                  advance;

    assign advance    = in_valid_reg && (!out_valid_reg || result_ready);
    assign tick_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                dmt_pkg::CFG_RELOAD_VALUE: cfg_reg.reload_value <= cfg_data;
                dmt_pkg::CFG_TIMER_ENABLE: cfg_reg.timer_enable <= cfg_data[0];
                dmt_pkg::CFG_CLOCK_SELECT: cfg_reg.clock_select <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    dmt_step u_step
    (
        .state      (state_reg),
        .cfg        (cfg_reg),
        .tick       (in_tick_reg),
        .state_next (state_next),
        .irq        (irq_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            in_tick_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg.div_pre       <= dmt_pkg::DIV_PRE_RESET;
            state_reg.div_cnt       <= 8'd0;
            state_reg.cnt_pre       <= dmt_pkg::CNT_PRE_RESET;
            state_reg.active_period <= 11'd0;
            state_reg.mod_cnt       <= 8'd0;
            state_reg.ovf_stage     <= 3'd0;
        end
        else
        begin
            if (tick_valid && tick_ready)
            begin
                in_valid_reg <= 1'b1;
                in_tick_reg  <= tick;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            div_out_reg <= state_next.div_cnt;
            cnt_out_reg <= state_next.mod_cnt;
            irq_out_reg <= irq_next;
        end
    end

    assign result_valid    = out_valid_reg;
    assign divider_value   = div_out_reg;
    assign counter_value   = cnt_out_reg;
    assign timer_interrupt = irq_out_reg;

endmodule

FILE: rtl/core/dmt_step.sv
// next-state logic for one cpu tick of the divider and modulo timer
module dmt_step
(
    input  dmt_pkg::timer_state_t state,
    input  dmt_pkg::timer_cfg_t   cfg,
    input  logic                  tick,
    output dmt_pkg::timer_state_t state_next,
    output logic                  irq
);

    logic [8:0]  div_dec;
    logic [2:0]  stage_inc;
    logic        reloaded;
    logic [10:0] period;
    logic [10:0] pre_start;
    logic [10:0] pre_dec;

    always_comb
    begin
        state_next = state;
        irq        = 1'b0;
        reloaded   = 1'b0;
        div_dec    = state.div_pre - 9'd1;
        stage_inc  = state.ovf_stage + 3'd1;
        period     = dmt_pkg::period_of(cfg.clock_select);
        pre_start  = (period != state.active_period) ? period : state.cnt_pre;
        pre_dec    = pre_start - 11'd1;

        if (tick)
        begin
            if (div_dec == 9'd0)
            begin
                state_next.div_cnt = state.div_cnt + 8'd1;
                state_next.div_pre = dmt_pkg::DIV_PERIOD;
            end
            else
            begin
                state_next.div_pre = div_dec;
            end

            // pending reload walks through its delay stages
            if (state.ovf_stage != 3'd0)
            begin
                if (stage_inc == dmt_pkg::RELOAD_STAGE)
                begin
                    state_next.mod_cnt   = cfg.reload_value;
                    state_next.ovf_stage = 3'd0;
                    irq                  = 1'b1;
                    reloaded             = 1'b1;
                end
                else
                begin
                    state_next.ovf_stage = stage_inc;
                end
            end

            if (!reloaded && cfg.timer_enable)
            begin
                state_next.active_period = period;
                if (pre_dec == 11'd0)
                begin
                    state_next.mod_cnt = state.mod_cnt + 8'd1;
                    state_next.cnt_pre = period;
                    if (state.mod_cnt == dmt_pkg::COUNT_MAX)
                    begin
                        state_next.ovf_stage = 3'd1;
                    end
                end
                else
                begin
                    state_next.cnt_pre = pre_dec;
                end
            end
        end
    end

endmodule

FILE: test/timer_result_checker.sv
// result checker for the divider and modulo timer: tracks state per tick beat, compares results
`timescale 1ns / 1ps
module timer_result_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       tick_valid,
    input  logic       tick_ready,
    input  logic       tick,
    input  logic       result_valid,
    input  logic       result_ready,
    input  logic [7:0] divider_value,
    input  logic [7:0] counter_value,
    input  logic       timer_interrupt,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    output int         mismatch_count,
    output int         pending_count,
    output int         results_checked,
    output int         interrupts_seen
);

    typedef struct packed
    {
        logic [7:0] divider;
        logic [7:0] counter;
        logic       irq;
    } timer_reading_t;

    dmt_pkg::timer_state_t timer_now;
    dmt_pkg::timer_cfg_t   timer_regs;
    timer_reading_t        expected_readings[$];

    function automatic logic [10:0] select_period(input logic [1:0] sel);
        logic [10:0] ticks;
        begin
            case (sel)
                dmt_pkg::SEL_16:  ticks = 11'd16;
                dmt_pkg::SEL_64:  ticks = 11'd64;
                dmt_pkg::SEL_256: ticks = 11'd256;
                default:          ticks = 11'd1024;
            endcase
            return ticks;
        end
    endfunction

    // one cpu tick of the divider and the modulo counter
    task automatic step_timer_state(input logic advance, output timer_reading_t reading);
        logic [10:0] wanted_period;
        logic [7:0]  count_before;
        logic        reloaded;
        begin
            reading.irq = 1'b0;
            reloaded = 1'b0;
            if (advance)
            begin
                timer_now.div_pre = timer_now.div_pre - 9'd1;
                if (timer_now.div_pre == 9'd0)
                begin
                    timer_now.div_cnt = timer_now.div_cnt + 8'd1;
                    timer_now.div_pre = dmt_pkg::DIV_PERIOD;
                end
                if (timer_now.ovf_stage != 3'd0)
                begin
                    timer_now.ovf_stage = timer_now.ovf_stage + 3'd1;
                    if (timer_now.ovf_stage == dmt_pkg::RELOAD_STAGE)
                    begin
                        timer_now.mod_cnt = timer_regs.reload_value;
                        timer_now.ovf_stage = 3'd0;
                        reading.irq = 1'b1;
                        reloaded = 1'b1;
                    end
                end
                // the reload tick skips the counting step
                if (!reloaded && timer_regs.timer_enable)
                begin
                    wanted_period = select_period(timer_regs.clock_select);
                    if (wanted_period != timer_now.active_period)
                    begin
                        timer_now.active_period = wanted_period;
                        timer_now.cnt_pre = wanted_period;
                    end
                    timer_now.cnt_pre = timer_now.cnt_pre - 11'd1;
                    if (timer_now.cnt_pre == 11'd0)
                    begin
                        count_before = timer_now.mod_cnt;
                        timer_now.mod_cnt = timer_now.mod_cnt + 8'd1;
                        timer_now.cnt_pre = timer_now.active_period;
                        if (count_before == dmt_pkg::COUNT_MAX)
                            timer_now.ovf_stage = 3'd1;
                    end
                end
            end
            reading.divider = timer_now.div_cnt;
            reading.counter = timer_now.mod_cnt;
        end
    endtask

    task automatic log_mismatch(input string what, input timer_reading_t want,
                                input timer_reading_t seen);
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t %s: expected div %0d cnt %0d irq %0d, got div %0d cnt %0d irq %0d",
                         $realtime, what, want.divider, want.counter, want.irq,
                         seen.divider, seen.counter, seen.irq);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        timer_reading_t seen;
        timer_reading_t want;
        if (!rst_n)
        begin
            timer_now.div_pre       = dmt_pkg::DIV_PRE_RESET;
            timer_now.div_cnt       = 8'd0;
            timer_now.cnt_pre       = dmt_pkg::CNT_PRE_RESET;
            timer_now.active_period = 11'd0;
            timer_now.mod_cnt       = 8'd0;
            timer_now.ovf_stage     = 3'd0;
            timer_regs              = '0;
            expected_readings.delete();
            mismatch_count          = 0;
            pending_count           = 0;
            results_checked         = 0;
            interrupts_seen         = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                seen = {divider_value, counter_value, timer_interrupt};
                if (expected_readings.size() == 0)
                begin
                    log_mismatch("result beat with nothing pending", '0, seen);
                end
                else
                begin
                    want = expected_readings.pop_front();
                    results_checked++;
                    if (want.irq)
                        interrupts_seen++;
                    if (seen.divider !== want.divider || seen.counter !== want.counter
                        || seen.irq !== want.irq)
                        log_mismatch("result beat", want, seen);
                end
            end
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    dmt_pkg::CFG_RELOAD_VALUE: timer_regs.reload_value = cfg_data;
                    dmt_pkg::CFG_TIMER_ENABLE: timer_regs.timer_enable = cfg_data[0];
                    dmt_pkg::CFG_CLOCK_SELECT: timer_regs.clock_select = cfg_data[1:0];
                    default: ;
                endcase
            end
            if (tick_valid && tick_ready)
            begin
                step_timer_state(tick, want);
                expected_readings.push_back(want);
            end
            pending_count = expected_readings.size();
        end
    end

endmodule

FILE: test/divider_and_modulo_timer_tb.sv
// testbench top of the divider and modulo timer: clock, reset, stimulus, setup and verdict
`timescale 1ns / 1ps
module divider_and_modulo_timer_tb;

    localparam int CYCLE_LIMIT       = 600000;
    localparam int SEGMENTS          = 12;
    localparam int BEATS_PER_SEGMENT = 125;
    localparam int WARMUP_IRQS       = 3;
    localparam int WARMUP_CAP        = 6000;

    logic       clk;
    logic       rst_n;
    logic       tick_valid;
    logic       tick_ready;
    logic       tick;
    logic       result_valid;
    logic       result_ready;
    logic [7:0] divider_value;
    logic [7:0] counter_value;
    logic       timer_interrupt;
    logic       cfg_wr_en;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    logic tick_taken;
    int   sender_idle_pct;
    int   receiver_idle_pct;
    int   beats_sent;
    int   cycle_count;
    int   mismatch_count;
    int   pending_count;
    int   results_checked;
    int   interrupts_seen;

    divider_and_modulo_timer dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .tick_valid      (tick_valid),
        .tick_ready      (tick_ready),
        .tick            (tick),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .divider_value   (divider_value),
        .counter_value   (counter_value),
        .timer_interrupt (timer_interrupt),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    timer_result_checker result_watch
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .tick_valid      (tick_valid),
        .tick_ready      (tick_ready),
        .tick            (tick),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .divider_value   (divider_value),
        .counter_value   (counter_value),
        .timer_interrupt (timer_interrupt),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .pending_count   (pending_count),
        .results_checked (results_checked),
        .interrupts_seen (interrupts_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // acceptance seen at the rising edge, read back at the next falling edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tick_taken <= 1'b0;
        else
            tick_taken <= tick_valid && tick_ready;
    end

    always @(negedge clk)
    begin
        result_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_tick(input logic advance);
        begin
            while ($urandom_range(99) < sender_idle_pct)
            begin
                tick_valid <= 1'b0;
                @(negedge clk);
            end
            tick_valid <= 1'b1;
            tick <= advance;
            @(negedge clk);
            while (!tick_taken)
                @(negedge clk);
            beats_sent++;
        end
    endtask

    task automatic drain_results();
        begin
            tick_valid <= 1'b0;
            @(negedge clk);
            while (pending_count != 0)
                @(negedge clk);
        end
    endtask

    // writes all three registers back to back, block must be idle
    task automatic program_timer(input logic [7:0] modulo, input logic enable,
                                 input logic [1:0] sel);
        begin
            drain_results();
            repeat (4) @(negedge clk);
            cfg_wr_en <= 1'b1;
            cfg_index <= dmt_pkg::CFG_RELOAD_VALUE;
            cfg_data  <= modulo;
            @(negedge clk);
            cfg_index <= dmt_pkg::CFG_TIMER_ENABLE;
            cfg_data  <= {7'd0, enable};
            @(negedge clk);
            cfg_index <= dmt_pkg::CFG_CLOCK_SELECT;
            cfg_data  <= {6'd0, sel};
            @(negedge clk);
            cfg_wr_en <= 1'b0;
            @(negedge clk);
        end
    endtask

    initial
    begin : stimulus
        int          seg;
        int          warm;
        logic [7:0]  modulo;
        logic        enable;
        logic [1:0]  sel;
        rst_n             = 1'b0;
        tick_valid        = 1'b0;
        tick              = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_index         = dmt_pkg::CFG_RELOAD_VALUE;
        cfg_data          = 8'd0;
        beats_sent        = 0;
        sender_idle_pct   = 22;
        receiver_idle_pct = 78;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // timer disabled after reset: idle and active ticks, only the divider moves
        send_tick(1'b0);
        send_tick(1'b0);
        repeat (6) send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);

        // fastest period, reload to the top value so overflows come back quickly
        program_timer(8'hFF, 1'b1, dmt_pkg::SEL_16);
        repeat (10) send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
        repeat (3) send_tick(1'b1);

        // count the modulo counter up to its first overflows
        warm = 0;
        while (interrupts_seen < WARMUP_IRQS && warm < WARMUP_CAP)
        begin
            send_tick(1'b1);
            warm++;
        end

        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            if (seg == SEGMENTS / 3)
            begin
                sender_idle_pct   = 78;
                receiver_idle_pct = 22;
            end
            else if (seg == 2 * SEGMENTS / 3)
            begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            case (seg)
                0:
                begin
                    modulo = 8'hFF;
                    enable = 1'b1;
                    sel    = dmt_pkg::SEL_1024;
                end
                1:
                begin
                    modulo = 8'hFE;
                    enable = 1'b0;
                    sel    = dmt_pkg::SEL_64;
                end
                2:
                begin
                    modulo = 8'($urandom_range(255));
                    enable = 1'b1;
                    sel    = dmt_pkg::SEL_256;
                end
                SEGMENTS - 1:
                begin
                    modulo = 8'h00;
                    enable = 1'b1;
                    sel    = dmt_pkg::SEL_16;
                end
                default:
                begin
                    // mostly near the top so the counter keeps overflowing
                    if ($urandom_range(3) == 0)
                        modulo = 8'($urandom_range(255));
                    else
                        modulo = 8'hF0 | 8'($urandom_range(15));
                    enable = ($urandom_range(3) != 0);
                    sel    = 2'($urandom_range(3));
                end
            endcase
            program_timer(modulo, enable, sel);
            repeat (BEATS_PER_SEGMENT)
            begin
                if ($urandom_range(149) == 0)
                    drain_results();
                send_tick($urandom_range(9) != 0);
            end
        end

        drain_results();
        repeat (8) @(negedge clk);

        $display("run covered %0d tick beats over %0d register settings, %0d results checked",
                 beats_sent, SEGMENTS + 2, results_checked);
        $display("timer interrupts seen: %0d, mismatches: %0d", interrupts_seen, mismatch_count);
        if (mismatch_count == 0 && pending_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
